// ===== hw/rtl/hashed_key_cache_fifo_evict_core_defines.svh =====
// Assertion macros for the hashed key cache.
`ifndef HASHED_KEY_CACHE_FIFO_EVICT_CORE_DEFINES_SVH
`define HASHED_KEY_CACHE_FIFO_EVICT_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define HKC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define HKC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define HKC_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define HKC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/hkc_pkg.sv =====
// Shared types and constants of the hashed key cache.
package hkc_pkg;
    localparam int NUM_ENTRIES = 64;
    localparam int NUM_BUCKETS = 32;
    localparam logic [31:0] HASH_SEED = 32'd5381;
    localparam int HASH_SHIFT = 5;
    localparam int KEY_W = 256;
    localparam int BC_W = 6;
    localparam int EL_W = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 7;
    localparam logic [BC_W-1:0] BC_RESET = 6'd32;
    localparam logic [EL_W-1:0] EL_RESET = 7'd64;
    localparam logic [CFG_IDX_W-1:0] REG_BUCKET_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_LIMIT = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_EMPTY = 2'd2;
    localparam logic [1:0] OP_NONE = 2'd3;

    typedef logic [5:0] t_slot;

    typedef struct packed {
        logic [1:0]  op;
        logic [63:0] key_word0;
        logic [63:0] key_word1;
        logic [63:0] key_word2;
        logic [63:0] key_word3;
        logic [63:0] value_word0;
        logic [63:0] value_word1;
        logic [63:0] value_word2;
        logic [63:0] value_word3;
    } t_in;

    typedef struct packed {
        logic        hit;
        logic        evicted;
        t_slot       slot;
        logic [63:0] out_word0;
        logic [63:0] out_word1;
        logic [63:0] out_word2;
        logic [63:0] out_word3;
    } t_out;
endpackage

// ===== hw/rtl/hkc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module hkc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_we,
    input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                    i_wdata,
    input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                    o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== hw/rtl/hkc_hash.sv =====
// djb2 hash of a 32-byte key, four bytes a cycle, then a bit-serial modulo.
module hkc_hash #(
    parameter int NUM_BUCKETS = hkc_pkg::NUM_BUCKETS
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_start,
    input  logic [hkc_pkg::KEY_W-1:0]                    i_key,
    input  logic [$clog2(NUM_BUCKETS+1)-1:0]             i_divisor,
    output logic                                         o_done,
    output logic [(NUM_BUCKETS>1?$clog2(NUM_BUCKETS):1)-1:0] o_bucket
);
    localparam int DVW = $clog2(NUM_BUCKETS + 1);
    localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_HASH = 2'd1;
    localparam logic [1:0] PH_DIV = 2'd2;

    logic [1:0]                r_phase, n_phase;
    logic [4:0]                r_cnt, n_cnt;
    logic                      r_done, n_done;
    logic [31:0]               r_h, n_h;
    logic [hkc_pkg::KEY_W-1:0] r_key, n_key;
    logic [DVW-1:0]            r_rem, n_rem;
    logic [DVW:0]              trial;
    logic [31:0]               acc;

    always_comb begin
        n_phase = r_phase;
        n_cnt = r_cnt;
        n_done = 1'b0;
        n_h = r_h;
        n_key = r_key;
        n_rem = r_rem;
        acc = r_h;
        trial = {r_rem, r_h[31]};
        case (r_phase)
            PH_IDLE: begin
                if (i_start) begin
                    n_phase = PH_HASH;
                    n_cnt = '0;
                    n_h = hkc_pkg::HASH_SEED;
                    n_key = i_key;
                end
            end
            PH_HASH: begin
                for (int j = 0; j < 4; j++) begin
                    acc = (acc << hkc_pkg::HASH_SHIFT) + acc
                        + {24'd0, r_key[hkc_pkg::KEY_W-1-8*j -: 8]};
                end
                n_h = acc;
                n_key = r_key << 32;
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd7) begin
                    n_phase = PH_DIV;
                    n_cnt = '0;
                    n_rem = '0;
                end
            end
            PH_DIV: begin
                // one quotient bit per cycle, remainder stays below the divisor
                if (trial >= {1'b0, i_divisor}) begin
                    n_rem = DVW'(trial - {1'b0, i_divisor});
                end else begin
                    n_rem = DVW'(trial);
                end
                n_h = r_h << 1;
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    n_phase = PH_IDLE;
                    n_done = 1'b1;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cnt <= '0;
            r_done <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_cnt <= n_cnt;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_h <= n_h;
        r_key <= n_key;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_bucket = BW'(r_rem);
endmodule

// ===== hw/rtl/hashed_key_cache_fifo_evict_core.sv =====
// Top level of the hashed key cache: control sequencer over the slot memories.
//
// A cache from 32-byte keys to 32-byte values with FIFO eviction. Issue a word
// by raising start while busy is low; exactly one result word follows, shown
// for a single cycle with o_done high, and it must be captured then since the
// block cannot be held off. Lookup and insert hash the key (four bytes a
// cycle) and reduce it modulo the bucket count (one bit a cycle), then work
// through the memories: lookup walks the bucket chain entry by entry, insert
// reads the candidate slot and then writes the entry and its links. Empty
// walks the age queue entry by entry. An unused op code answers the next cycle
// with zeros. Configuration writes are taken only while idle; a write to either
// register clears the table at once, and reset does the same. State lives in
// single-port-read RAMs with registered read data; the chain walk is bounded
// by the number of entries.
module hashed_key_cache_fifo_evict_core #(
    parameter int NUM_ENTRIES = hkc_pkg::NUM_ENTRIES,
    parameter int NUM_BUCKETS = hkc_pkg::NUM_BUCKETS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  hkc_pkg::t_in                      i_in,
    output logic                              o_done,
    output hkc_pkg::t_out                     o_out,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [hkc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [hkc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    `include "hashed_key_cache_fifo_evict_core_defines.svh"

    localparam int SW = $clog2(NUM_ENTRIES + 1);   // slot code incl. null
    localparam int IW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int DVW = $clog2(NUM_BUCKETS + 1);
    localparam int KW = hkc_pkg::KEY_W;
    localparam logic [SW-1:0] NIL = SW'(NUM_ENTRIES);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_HASH   = 4'd1;
    localparam logic [3:0] S_HRD    = 4'd2;
    localparam logic [3:0] S_L_HEAD = 4'd3;
    localparam logic [3:0] S_L_CMP  = 4'd4;
    localparam logic [3:0] S_I_RD   = 4'd5;
    localparam logic [3:0] S_I_UPD  = 4'd6;
    localparam logic [3:0] S_I_W2   = 4'd7;
    localparam logic [3:0] S_I_W3   = 4'd8;
    localparam logic [3:0] S_E_RD   = 4'd9;
    localparam logic [3:0] S_E_WR   = 4'd10;

    // control state
    logic [3:0]               r_state, n_state;
    logic [hkc_pkg::BC_W-1:0] r_bc, n_bc;
    logic [hkc_pkg::EL_W-1:0] r_el, n_el;
    logic [SW-1:0]            r_oldest, n_oldest;
    logic [SW-1:0]            r_newest, n_newest;
    logic [SW-1:0]            r_free, n_free;
    logic [SW-1:0]            r_used, n_used;
    logic [NUM_ENTRIES-1:0]   r_age_vld, n_age_vld;
    logic [NUM_BUCKETS-1:0]   r_head_vld, n_head_vld;
    logic                     r_done, n_done;
    // working payload
    logic [1:0]               r_op, n_op;
    logic [KW-1:0]            r_key, n_key;
    logic [KW-1:0]            r_val, n_val;
    logic [BW-1:0]            r_b, n_b;
    logic [SW-1:0]            r_e, n_e;
    logic [SW-1:0]            r_n, n_n;
    logic [SW-1:0]            r_h, n_h;
    logic                     r_ev, n_ev;
    hkc_pkg::t_out            r_out, n_out;

    // hash unit
    logic                     hash_start, hash_done;
    logic [BW-1:0]            hash_bucket;
    logic [DVW-1:0]           div_used;
    logic [SW-1:0]            lim_used;

    // memory ports
    logic [SW-1:0]  rd_slot;
    logic [IW-1:0]  rd_idx;
    logic [KW-1:0]  key_rd, val_rd;
    logic           kv_we;
    logic [SW-1:0]  next_rd, prev_rd, age_rd, head_rd;
    logic [BW-1:0]  sbkt_rd;
    logic           next_we, prev_we, age_we, head_we;
    logic [IW-1:0]  next_wa, prev_wa, age_wa;
    logic [SW-1:0]  next_wd, prev_wd, age_wd;

    logic [SW-1:0]  age_nx, head_cur, cand, cnt1;
    logic           evict_now;

    // effective register values: saturate, then raise the limit to the bucket count
    always_comb begin
        int bu;
        int lim;
        bu = int'(r_bc);
        if (bu < 1) bu = 1;
        if (bu > NUM_BUCKETS) bu = NUM_BUCKETS;
        lim = int'(r_el);
        if (lim < 1) lim = 1;
        if (lim > NUM_ENTRIES) lim = NUM_ENTRIES;
        if (lim < bu) lim = bu;
        if (lim > NUM_ENTRIES) lim = NUM_ENTRIES;
        div_used = DVW'(bu);
        lim_used = SW'(lim);
    end

    assign busy = (r_state != S_IDLE) || i_cfg_valid;
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_done = r_done;
    assign o_out = r_out;

    assign rd_idx = rd_slot[IW-1:0];
    // a slot never written since clear links to the one after it
    assign age_nx = r_age_vld[r_e[IW-1:0]] ? age_rd : (r_e + SW'(1));
    assign head_cur = r_head_vld[r_b] ? head_rd : NIL;
    assign evict_now = (r_used >= lim_used);
    assign cand = evict_now ? r_oldest : r_free;
    assign cnt1 = r_n + SW'(1);

    always_comb begin
        n_state = r_state;
        n_bc = r_bc;
        n_el = r_el;
        n_oldest = r_oldest;
        n_newest = r_newest;
        n_free = r_free;
        n_used = r_used;
        n_age_vld = r_age_vld;
        n_head_vld = r_head_vld;
        n_done = 1'b0;
        n_op = r_op;
        n_key = r_key;
        n_val = r_val;
        n_b = r_b;
        n_e = r_e;
        n_n = r_n;
        n_h = r_h;
        n_ev = r_ev;
        n_out = r_out;
        hash_start = 1'b0;
        rd_slot = r_e;
        kv_we = 1'b0;
        next_we = 1'b0; next_wa = r_e[IW-1:0]; next_wd = NIL;
        prev_we = 1'b0; prev_wa = r_e[IW-1:0]; prev_wd = NIL;
        age_we = 1'b0;  age_wa = r_e[IW-1:0];  age_wd = NIL;
        head_we = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_cfg_valid) begin
                    if (i_cfg_index == hkc_pkg::REG_BUCKET_COUNT ||
                        i_cfg_index == hkc_pkg::REG_ENTRY_LIMIT) begin
                        if (i_cfg_index == hkc_pkg::REG_BUCKET_COUNT) begin
                            n_bc = i_cfg_data[hkc_pkg::BC_W-1:0];
                        end else begin
                            n_el = i_cfg_data[hkc_pkg::EL_W-1:0];
                        end
                        n_age_vld = '0;
                        n_head_vld = '0;
                        n_oldest = NIL;
                        n_newest = NIL;
                        n_free = '0;
                        n_used = '0;
                    end
                end else if (start) begin
                    n_op = i_in.op;
                    n_key = {i_in.key_word0, i_in.key_word1,
                             i_in.key_word2, i_in.key_word3};
                    n_val = {i_in.value_word0, i_in.value_word1,
                             i_in.value_word2, i_in.value_word3};
                    n_out = '0;
                    case (i_in.op)
                        hkc_pkg::OP_NONE: begin
                            n_done = 1'b1;
                        end
                        hkc_pkg::OP_EMPTY: begin
                            n_e = r_oldest;
                            n_n = '0;
                            n_state = S_E_RD;
                        end
                        default: begin
                            hash_start = 1'b1;
                            n_state = S_HASH;
                        end
                    endcase
                end
            end
            S_HASH: begin
                if (hash_done) begin
                    n_b = hash_bucket;
                    n_state = S_HRD;
                end
            end
            S_HRD: begin
                // bucket head read is in flight
                n_state = (r_op == hkc_pkg::OP_LOOKUP) ? S_L_HEAD : S_I_RD;
            end
            S_L_HEAD: begin
                if (head_cur < NIL) begin
                    rd_slot = head_cur;
                    n_e = head_cur;
                    n_n = '0;
                    n_state = S_L_CMP;
                end else begin
                    n_done = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_L_CMP: begin
                if (key_rd == r_key) begin
                    n_out.hit = 1'b1;
                    n_out.slot = hkc_pkg::t_slot'(r_e);
                    {n_out.out_word0, n_out.out_word1,
                     n_out.out_word2, n_out.out_word3} = val_rd;
                    n_done = 1'b1;
                    n_state = S_IDLE;
                end else if (next_rd < NIL && cnt1 < NIL) begin
                    rd_slot = next_rd;
                    n_e = next_rd;
                    n_n = cnt1;
                end else begin
                    n_done = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_I_RD: begin
                if (cand < NIL) begin
                    rd_slot = cand;
                    n_e = cand;
                    n_ev = evict_now;
                    n_state = S_I_UPD;
                end else begin
                    n_done = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_I_UPD: begin
                if (r_ev) begin
                    // oldest entry is the tail of its chain
                    n_oldest = age_nx;
                    if (prev_rd < NIL) begin
                        next_we = 1'b1;
                        next_wa = prev_rd[IW-1:0];
                        next_wd = NIL;
                    end else begin
                        n_head_vld[sbkt_rd] = 1'b0;
                    end
                end else begin
                    n_used = r_used + SW'(1);
                    n_free = age_nx;
                end
                if (r_ev && !(prev_rd < NIL) && sbkt_rd == r_b) begin
                    n_h = NIL;
                end else begin
                    n_h = head_cur;
                end
                n_state = S_I_W2;
            end
            S_I_W2: begin
                kv_we = 1'b1;
                next_we = 1'b1;
                next_wd = r_h;
                prev_we = 1'b1;
                age_we = 1'b1;
                n_age_vld[r_e[IW-1:0]] = 1'b1;
                head_we = 1'b1;
                n_head_vld[r_b] = 1'b1;
                n_state = S_I_W3;
            end
            S_I_W3: begin
                if (r_h < NIL) begin
                    prev_we = 1'b1;
                    prev_wa = r_h[IW-1:0];
                    prev_wd = r_e;
                end
                if (r_newest < NIL && r_newest != r_e) begin
                    age_we = 1'b1;
                    age_wa = r_newest[IW-1:0];
                    age_wd = r_e;
                    n_age_vld[r_newest[IW-1:0]] = 1'b1;
                end
                n_newest = r_e;
                if (!(r_oldest < NIL)) begin
                    n_oldest = r_e;
                end
                n_out.hit = 1'b1;
                n_out.evicted = r_ev;
                n_out.slot = hkc_pkg::t_slot'(r_e);
                {n_out.out_word0, n_out.out_word1,
                 n_out.out_word2, n_out.out_word3} = r_val;
                n_done = 1'b1;
                n_state = S_IDLE;
            end
            S_E_RD: begin
                if (r_e < NIL && r_n < NIL) begin
                    n_state = S_E_WR;
                end else begin
                    n_head_vld = '0;
                    n_oldest = NIL;
                    n_newest = NIL;
                    n_used = '0;
                    n_done = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_E_WR: begin
                // push onto the front of the free list
                age_we = 1'b1;
                age_wd = r_free;
                n_age_vld[r_e[IW-1:0]] = 1'b1;
                n_free = r_e;
                n_e = age_nx;
                n_n = cnt1;
                n_state = S_E_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_bc <= hkc_pkg::BC_RESET;
            r_el <= hkc_pkg::EL_RESET;
            r_oldest <= NIL;
            r_newest <= NIL;
            r_free <= '0;
            r_used <= '0;
            r_age_vld <= '0;
            r_head_vld <= '0;
            r_done <= 1'b0;
        end else begin
            r_state <= n_state;
            r_bc <= n_bc;
            r_el <= n_el;
            r_oldest <= n_oldest;
            r_newest <= n_newest;
            r_free <= n_free;
            r_used <= n_used;
            r_age_vld <= n_age_vld;
            r_head_vld <= n_head_vld;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op;
        r_key <= n_key;
        r_val <= n_val;
        r_b <= n_b;
        r_e <= n_e;
        r_n <= n_n;
        r_h <= n_h;
        r_ev <= n_ev;
        r_out <= n_out;
    end

    hkc_hash #(.NUM_BUCKETS(NUM_BUCKETS)) u_hash (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(hash_start),
        .i_key({i_in.key_word0, i_in.key_word1, i_in.key_word2, i_in.key_word3}),
        .i_divisor(div_used), .o_done(hash_done), .o_bucket(hash_bucket)
    );

    hkc_ram #(.WIDTH(KW), .DEPTH(NUM_ENTRIES)) u_key_ram (
        .i_clk(i_clk), .i_we(kv_we), .i_waddr(r_e[IW-1:0]), .i_wdata(r_key),
        .i_raddr(rd_idx), .o_rdata(key_rd)
    );
    hkc_ram #(.WIDTH(KW), .DEPTH(NUM_ENTRIES)) u_val_ram (
        .i_clk(i_clk), .i_we(kv_we), .i_waddr(r_e[IW-1:0]), .i_wdata(r_val),
        .i_raddr(rd_idx), .o_rdata(val_rd)
    );
    hkc_ram #(.WIDTH(BW), .DEPTH(NUM_ENTRIES)) u_sbkt_ram (
        .i_clk(i_clk), .i_we(kv_we), .i_waddr(r_e[IW-1:0]), .i_wdata(r_b),
        .i_raddr(rd_idx), .o_rdata(sbkt_rd)
    );
    hkc_ram #(.WIDTH(SW), .DEPTH(NUM_ENTRIES)) u_next_ram (
        .i_clk(i_clk), .i_we(next_we), .i_waddr(next_wa), .i_wdata(next_wd),
        .i_raddr(rd_idx), .o_rdata(next_rd)
    );
    hkc_ram #(.WIDTH(SW), .DEPTH(NUM_ENTRIES)) u_prev_ram (
        .i_clk(i_clk), .i_we(prev_we), .i_waddr(prev_wa), .i_wdata(prev_wd),
        .i_raddr(rd_idx), .o_rdata(prev_rd)
    );
    hkc_ram #(.WIDTH(SW), .DEPTH(NUM_ENTRIES)) u_age_ram (
        .i_clk(i_clk), .i_we(age_we), .i_waddr(age_wa), .i_wdata(age_wd),
        .i_raddr(rd_idx), .o_rdata(age_rd)
    );
    hkc_ram #(.WIDTH(SW), .DEPTH(NUM_BUCKETS)) u_head_ram (
        .i_clk(i_clk), .i_we(head_we), .i_waddr(r_b), .i_wdata(r_e),
        .i_raddr(r_b), .o_rdata(head_rd)
    );

    `HKC_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy || o_done)
    `HKC_ASSERT_SAME(a_used_bound, i_clk, i_rst_n, 1'b1, r_used <= NIL)
    `HKC_ASSERT_SAME(a_evict_hit, i_clk, i_rst_n, o_done && o_out.evicted, o_out.hit)
endmodule

// ===== tb/sv/hashed_key_cache_fifo_evict_core_tb.sv =====
// Self-checking testbench of the hashed key cache with FIFO eviction.
`timescale 1ns / 1ps

module hashed_key_cache_fifo_evict_core_tb;
    import hkc_pkg::*;

    localparam int NIL = NUM_ENTRIES;
    localparam int LIMIT_CYCLES = 2000000;

    logic          i_clk;
    logic          i_rst_n;
    logic          start;
    logic          busy;
    t_in           i_in;
    logic          o_done;
    t_out          o_out;
    logic          i_cfg_valid;
    logic          o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    hashed_key_cache_fifo_evict_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_in       (i_in),
        .o_done     (o_done),
        .o_out      (o_out),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        i_clk = 1'b0; #5;
        i_clk = 1'b1; #5;
    end

    // ---------------------------------------------------------------
    // Cache model: our own copy of the table, configuration and links.
    // ---------------------------------------------------------------
    logic [5:0]   bucket_reg;
    logic [6:0]   limit_reg;
    logic [255:0] slot_key [NUM_ENTRIES];
    logic [255:0] slot_val [NUM_ENTRIES];
    int           chain_nx [NUM_ENTRIES];
    int           chain_pv [NUM_ENTRIES];
    int           age_nx   [NUM_ENTRIES];
    int           head_of  [NUM_BUCKETS];
    int           oldest, newest, free_top, used;

    t_out expected_words[$];
    int   fails;
    int   cycles;

    function automatic int eff_buckets();
        int b;
        b = bucket_reg;
        if (b < 1) b = 1;
        if (b > NUM_BUCKETS) b = NUM_BUCKETS;
        return b;
    endfunction

    function automatic int eff_limit();
        int e;
        e = limit_reg;
        if (e < 1) e = 1;
        if (e > NUM_ENTRIES) e = NUM_ENTRIES;
        if (e < eff_buckets()) e = eff_buckets();
        if (e > NUM_ENTRIES) e = NUM_ENTRIES;
        return e;
    endfunction

    // djb2 over 32 key bytes, byte 0 in the top bits
    function automatic int bucket_index(logic [255:0] key);
        logic [31:0] h;
        h = HASH_SEED;
        for (int i = 31; i >= 0; i--)
            h = (h << HASH_SHIFT) + h + {24'd0, key[i*8 +: 8]};
        return int'(h % eff_buckets());
    endfunction

    function automatic void table_clear();
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            slot_key[i] = '0;
            slot_val[i] = '0;
            chain_nx[i] = NIL;
            chain_pv[i] = NIL;
            age_nx[i]   = i + 1;
        end
        for (int i = 0; i < NUM_BUCKETS; i++) head_of[i] = NIL;
        oldest = NIL; newest = NIL; free_top = 0; used = 0;
    endfunction

    function automatic void cfg_model(logic [CFG_IDX_W-1:0] idx, logic [6:0] val);
        if (idx == REG_BUCKET_COUNT) bucket_reg = val[5:0];
        else if (idx == REG_ENTRY_LIMIT) limit_reg = val;
        else return;
        table_clear();
    endfunction

    function automatic t_out result_word(bit hit, bit ev, int s);
        t_out r;
        r = '0;
        r.hit = hit; r.evicted = ev; r.slot = s[5:0];
        {r.out_word0, r.out_word1, r.out_word2, r.out_word3} = slot_val[s];
        return r;
    endfunction

    function automatic t_out cache_step(t_in w);
        logic [255:0] key;
        int b, e, p, n;
        bit ev;
        key = {w.key_word0, w.key_word1, w.key_word2, w.key_word3};
        ev = 0;
        if (w.op == OP_EMPTY) begin
            e = oldest; n = 0;
            while (e < NIL && n < NUM_ENTRIES) begin
                p = age_nx[e];
                age_nx[e] = free_top;
                chain_nx[e] = NIL; chain_pv[e] = NIL;
                free_top = e;
                slot_key[e] = '0; slot_val[e] = '0;
                e = p; n++;
            end
            for (int i = 0; i < NUM_BUCKETS; i++) head_of[i] = NIL;
            oldest = NIL; newest = NIL; used = 0;
            return '0;
        end
        if (w.op == OP_NONE) return '0;
        b = bucket_index(key);
        if (w.op == OP_LOOKUP) begin
            e = head_of[b]; n = 0;
            while (e < NIL && n < NUM_ENTRIES) begin
                if (slot_key[e] == key) return result_word(1, 0, e);
                e = chain_nx[e]; n++;
            end
            return '0;
        end
        if (used >= eff_limit()) begin
            e = oldest;
            if (e >= NIL) return '0;
            oldest = age_nx[e];
            p = chain_pv[e];
            if (p < NIL) chain_nx[p] = NIL;
            else head_of[bucket_index(slot_key[e])] = NIL;
            ev = 1;
        end else begin
            e = free_top;
            if (e >= NIL) return '0;
            used++;
            free_top = age_nx[e];
        end
        chain_pv[e] = NIL; chain_nx[e] = NIL; age_nx[e] = NIL;
        slot_key[e] = key;
        slot_val[e] = {w.value_word0, w.value_word1, w.value_word2, w.value_word3};
        if (newest < NIL && newest != e) age_nx[newest] = e;
        newest = e;
        if (oldest >= NIL) oldest = e;
        if (head_of[b] < NIL) begin
            chain_pv[head_of[b]] = e;
            chain_nx[e] = head_of[b];
        end
        head_of[b] = e;
        return result_word(1, ev, e);
    endfunction

    // ---------------------------------------------------------------
    // Result checker: every strobe must match the oldest expectation.
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            t_out want;
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected result word %h", $time, o_out);
                fails++;
            end else begin
                want = expected_words.pop_front();
                if (o_out.hit !== want.hit || o_out.evicted !== want.evicted
                        || o_out.slot !== want.slot) begin
                    $display("%0t: hit/evicted/slot expected %b/%b/%0d got %b/%b/%0d",
                             $time, want.hit, want.evicted, want.slot,
                             o_out.hit, o_out.evicted, o_out.slot);
                    fails++;
                end
                if (o_out.out_word0 !== want.out_word0 || o_out.out_word1 !== want.out_word1
                        || o_out.out_word2 !== want.out_word2
                        || o_out.out_word3 !== want.out_word3) begin
                    $display("%0t: value expected %h got %h", $time,
                             {want.out_word0, want.out_word1, want.out_word2, want.out_word3},
                             {o_out.out_word0, o_out.out_word1, o_out.out_word2,
                              o_out.out_word3});
                    fails++;
                end
            end
        end
    end

    // Watchdog: ends a hung run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("hashed_key_cache_fifo_evict_core_tb: FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    logic [255:0] key_pool[16];
    bit           quiet_stretch;

    // sends one command word; checks the typed-in answer when given.
    // start stays high after the accepting edge until the next word or an idle cycle
    task automatic issue(t_in w, bit has_fixed, t_out fixed);
        t_out pred;
        while (!quiet_stretch && $urandom_range(99) < 35) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_in  <= w;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pred = cache_step(w);
        if (has_fixed && pred !== fixed) begin
            $display("%0t: table row expected %h predicted %h", $time, fixed, pred);
            fails++;
        end
        expected_words.push_back(pred);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        // settle before the next phase
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [6:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cfg_model(idx, val);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [63:0] rnd64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic t_in make_word(logic [1:0] op, logic [255:0] key, logic [255:0] val);
        t_in w;
        w.op = op;
        {w.key_word0, w.key_word1, w.key_word2, w.key_word3} = key;
        {w.value_word0, w.value_word1, w.value_word2, w.value_word3} = val;
        return w;
    endfunction

    typedef struct {
        logic [1:0]   op;
        logic [255:0] key;
        logic [255:0] val;
        bit           has_fixed;
        t_out         fixed;
    } t_row;

    t_row dir_rows[$];

    task automatic run_random(int count, int pool_size);
        logic [255:0] key;
        int r;
        for (int n = 0; n < count; n++) begin
            quiet_stretch = (n >= count / 3 && n < count / 2);
            r = $urandom_range(99);
            key = (r < 85) ? key_pool[$urandom_range(pool_size - 1)]
                           : {rnd64(), rnd64(), rnd64(), rnd64()};
            if (r < 45)
                issue(make_word(OP_LOOKUP, key, {rnd64(), rnd64(), rnd64(), rnd64()}), 0, '0);
            else if (r < 92)
                issue(make_word(OP_INSERT, key, {rnd64(), rnd64(), rnd64(), rnd64()}), 0, '0);
            else if (r < 96)
                issue(make_word(OP_EMPTY, key, '0), 0, '0);
            else
                issue(make_word(OP_NONE, key, {rnd64(), rnd64(), rnd64(), rnd64()}), 0, '0);
        end
        quiet_stretch = 0;
    endtask

    initial begin
        t_out hit_ones;
        fails = 0; cycles = 0; quiet_stretch = 0;
        i_rst_n = 1'b0; start = 1'b0; i_in = '0;
        i_cfg_valid = 1'b0; i_cfg_index = '0; i_cfg_data = '0;
        bucket_reg = BC_RESET; limit_reg = EL_RESET;
        table_clear();
        for (int i = 0; i < 16; i++) key_pool[i] = {rnd64(), rnd64(), rnd64(), rnd64()};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table: empty-table answers, extremes, every op
        hit_ones = '0;
        hit_ones.hit = 1'b1;
        hit_ones.slot = 6'd0;
        {hit_ones.out_word0, hit_ones.out_word1, hit_ones.out_word2, hit_ones.out_word3} = '1;
        dir_rows.push_back('{OP_LOOKUP, '0, '0, 1, '0});
        dir_rows.push_back('{OP_LOOKUP, '1, '1, 1, '0});
        dir_rows.push_back('{OP_NONE, '1, '1, 1, '0});
        dir_rows.push_back('{OP_INSERT, '1, '1, 1, hit_ones});
        dir_rows.push_back('{OP_LOOKUP, '1, '0, 1, hit_ones});
        dir_rows.push_back('{OP_INSERT, '0, '0, 0, '0});
        dir_rows.push_back('{OP_LOOKUP, '0, '1, 0, '0});
        dir_rows.push_back('{OP_INSERT, '1, {4{64'h5555_AAAA_0F0F_F0F0}}, 0, '0});
        dir_rows.push_back('{OP_LOOKUP, '1, '0, 0, '0});
        dir_rows.push_back('{OP_EMPTY, '1, '1, 1, '0});
        dir_rows.push_back('{OP_LOOKUP, '1, '0, 1, '0});
        dir_rows.push_back('{OP_INSERT, key_pool[0], '1, 0, '0});
        dir_rows.push_back('{OP_LOOKUP, key_pool[0], '0, 0, '0});
        foreach (dir_rows[i])
            issue(make_word(dir_rows[i].op, dir_rows[i].key, dir_rows[i].val),
                  dir_rows[i].has_fixed, dir_rows[i].fixed);

        // hold off until everything is back, then a long random phase
        drain();
        run_random(350, 16);

        // single bucket, single entry: an insert evicts whenever the entry is in use
        drain();
        write_cfg(REG_BUCKET_COUNT, 7'd1);
        write_cfg(REG_ENTRY_LIMIT, 7'd1);
        run_random(100, 3);

        // out-of-range registers: zero buckets, limit below buckets, high bits
        drain();
        write_cfg(REG_BUCKET_COUNT, 7'd0);
        write_cfg(REG_ENTRY_LIMIT, 7'd0);
        run_random(60, 4);
        drain();
        write_cfg(REG_BUCKET_COUNT, 7'd63);
        write_cfg(REG_ENTRY_LIMIT, 7'd5);
        run_random(100, 16);
        drain();
        write_cfg(REG_BUCKET_COUNT, 7'h7F);
        write_cfg(REG_ENTRY_LIMIT, 7'h7F);
        write_cfg(2'd3, 7'h55);
        run_random(90, 16);

        // small table, few buckets: deep chains and frequent eviction; then the reset values again
        drain();
        write_cfg(REG_BUCKET_COUNT, 7'd3);
        write_cfg(REG_ENTRY_LIMIT, 7'd6);
        run_random(150, 10);
        drain();
        write_cfg(REG_BUCKET_COUNT, 7'd32);
        write_cfg(REG_ENTRY_LIMIT, 7'd64);
        run_random(90, 16);

        drain();
        if (fails == 0)
            $display("hashed_key_cache_fifo_evict_core_tb: PASS");
        else
            $display("hashed_key_cache_fifo_evict_core_tb: FAIL");
        $finish;
    end
endmodule
